FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/lrupr_pkg.sv
// Types and constants of the LRU page replacement block.
`default_nettype none
package lrupr_pkg;

    localparam int PORT_PAGE_W = 16;
    localparam int CFG_W       = 5;
    localparam int TOTAL_W     = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture page and register the match vector
        logic update;  // shift the stack, write the result registers
    } t_dp_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/lrupr_ctrl.sv
// Sequencing controller of the LRU page replacement block.
`default_nettype none
module lrupr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire                  i_ready,
    output logic                 o_ready,
    output logic                 o_valid,
    output lrupr_pkg::t_dp_cmd   o_cmd
);

    lrupr_pkg::t_state r_state;
    lrupr_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_take;
    logic              w_upd;

    assign w_take = (r_state == lrupr_pkg::S_IDLE) && i_valid;
    // the result register must be free, or emptying this cycle
    assign w_upd  = (r_state == lrupr_pkg::S_UPD) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lrupr_pkg::S_IDLE: begin
                if (w_take) begin
                    n_state = lrupr_pkg::S_UPD;
                end
            end
            lrupr_pkg::S_UPD: begin
                if (w_upd) begin
                    n_state = lrupr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lrupr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_upd) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrupr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready      = (r_state == lrupr_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_cmd.load   = w_take;
    assign o_cmd.update = w_upd;

endmodule
`default_nettype wire

FILE: hw/rtl/lrupr_dp.sv
// Datapath: recency stack of compare-and-shift cells, counters, result registers.
`default_nettype none
`include "assert_macros.svh"
module lrupr_dp #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  lrupr_pkg::t_dp_cmd                      i_cmd,
    input  wire                                     i_cfg_we,
    input  wire  [lrupr_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  wire  [lrupr_pkg::PORT_PAGE_W-1:0]       i_page,
    input  wire                                     i_end_of_run,
    output logic                                    o_fault,
    output logic                                    o_evicted_valid,
    output logic [lrupr_pkg::PORT_PAGE_W-1:0]       o_evicted_page,
    output logic [lrupr_pkg::TOTAL_W-1:0]           o_fault_total
);

    localparam int PW    = lrupr_pkg::PORT_PAGE_W;
    localparam int CW    = lrupr_pkg::CFG_W;
    localparam int TW    = lrupr_pkg::TOTAL_W;
    localparam int OCC_W = $clog2(FRAMES_MAX + 1);
    localparam int IDX_W = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
    localparam int CNT_W = (OCC_W > CW) ? OCC_W : CW;

    logic [PAGE_BITS-1:0]  r_stack [FRAMES_MAX];
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_eor;
    logic [FRAMES_MAX-1:0] r_match;
    logic [OCC_W-1:0]      r_occ;
    logic [TW-1:0]         r_faults;
    logic [CW-1:0]         r_frame_count;
    logic                  r_fault;
    logic                  r_ev_valid;
    logic [PW-1:0]         r_ev_page;
    logic [TW-1:0]         r_total;

    logic [PAGE_BITS-1:0]  w_in_page;
    logic [FRAMES_MAX-1:0] w_valid;
    logic [FRAMES_MAX-1:0] w_match;
    logic [FRAMES_MAX-1:0] w_low;
    logic [FRAMES_MAX-1:0] w_thermo;
    logic [FRAMES_MAX-1:0] w_shift;
    logic [CNT_W-1:0]      w_fc_ext;
    logic [CNT_W-1:0]      w_frames_c;
    logic [OCC_W-1:0]      w_frames;
    logic                  w_hit;
    logic                  w_room;
    logic [OCC_W-1:0]      w_occ_m1;
    logic [PAGE_BITS-1:0]  w_bottom;
    logic [PW-1:0]         w_bottom_port;
    logic [TW-1:0]         w_faults_inc;

    // port page <-> stored page width
    generate
        if (PAGE_BITS == PW) begin : g_pw_eq
            assign w_in_page     = i_page;
            assign w_bottom_port = w_bottom;
        end else if (PAGE_BITS > PW) begin : g_pw_wide
            assign w_in_page     = {{(PAGE_BITS-PW){1'b0}}, i_page};
            assign w_bottom_port = w_bottom[PW-1:0];
        end else begin : g_pw_narrow
            assign w_in_page     = i_page[PAGE_BITS-1:0];
            assign w_bottom_port = {{(PW-PAGE_BITS){1'b0}}, w_bottom};
        end
    endgenerate

    // one compare cell per stack entry
    genvar g;
    generate
        for (g = 0; g < FRAMES_MAX; g++) begin : g_cell
            assign w_valid[g] = (r_occ > OCC_W'(g));
            assign w_match[g] = w_valid[g] && (r_stack[g] == w_in_page);
            assign w_shift[g] = w_hit  ? w_thermo[g] :
                                w_room ? (OCC_W'(g) <= r_occ) : (OCC_W'(g) < r_occ);
        end
    endgenerate

    // frame count clamped to 1..FRAMES_MAX
    assign w_fc_ext   = CNT_W'(r_frame_count);
    assign w_frames_c = (w_fc_ext == '0) ? CNT_W'(1) :
                        (w_fc_ext > CNT_W'(FRAMES_MAX)) ? CNT_W'(FRAMES_MAX) : w_fc_ext;
    assign w_frames   = w_frames_c[OCC_W-1:0];

    assign w_hit    = |r_match;
    assign w_room   = (r_occ < w_frames);
    // lowest set bit, then every entry from the top down to the hit moves
    assign w_low    = r_match & (~r_match + FRAMES_MAX'(1));
    assign w_thermo = w_low | (w_low - FRAMES_MAX'(1));
    assign w_occ_m1 = r_occ - OCC_W'(1);
    assign w_bottom = r_stack[w_occ_m1[IDX_W-1:0]];

    assign w_faults_inc = (!w_hit && (r_faults != '1)) ? (r_faults + TW'(1)) : r_faults;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page  <= w_in_page;
            r_eor   <= i_end_of_run;
            r_match <= w_match;
        end
        if (i_cmd.update) begin
            r_stack[0] <= r_page;
            for (int k = 1; k < FRAMES_MAX; k++) begin
                if (w_shift[k]) begin
                    r_stack[k] <= r_stack[k-1];
                end
            end
            r_fault    <= !w_hit;
            r_ev_valid <= !w_hit && !w_room;
            r_ev_page  <= (!w_hit && !w_room) ? w_bottom_port : '0;
            r_total    <= w_faults_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ         <= '0;
            r_faults      <= '0;
            r_frame_count <= lrupr_pkg::FRAMES_RESET;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                if (r_eor) begin
                    r_occ    <= '0;
                    r_faults <= '0;
                end else begin
                    if (!w_hit && w_room) begin
                        r_occ <= r_occ + OCC_W'(1);
                    end
                    r_faults <= w_faults_inc;
                end
            end
        end
    end

    assign o_fault         = r_fault;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_total;

    // resident pages are unique, so at most one cell matches
    `ASSERT_IMPL(a_match_unique, i_clk, i_rst_n, i_cmd.update, $onehot0(r_match), "duplicate resident page")
    `ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(FRAMES_MAX), "occupancy over depth")
    `ASSERT_NEXT(a_evict_fault, i_clk, i_rst_n, i_cmd.update, !r_ev_valid || r_fault, "eviction on a hit")
    `ASSERT_NEXT(a_fault_count, i_clk, i_rst_n, i_cmd.update, !r_fault || (r_total != '0), "fault not counted")

endmodule
`default_nettype wire

FILE: hw/rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block.
// Each reference has an accept step, which compares the page against every
// resident stack entry at once into a registered match vector, and an update step,
// which shifts the recency stack and loads the result register, after which the next
// transaction is accepted. The update step waits while an earlier result is still
// not taken. The recency stack needs no clearing pass, so the block is ready right
// after reset. frame_count is clamped to 1..FRAMES_MAX; end_of_run empties the table
// and the fault count after its own result.
`default_nettype none
module lru_page_replacement #(
    parameter int FRAMES_MAX = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [lrupr_pkg::PORT_PAGE_W-1:0]   i_page,
    input  wire                                 i_end_of_run,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic                                o_fault,
    output logic                                o_evicted_valid,
    output logic [lrupr_pkg::PORT_PAGE_W-1:0]   o_evicted_page,
    output logic [lrupr_pkg::TOTAL_W-1:0]       o_fault_total,
    input  wire                                 i_cfg_we,
    input  wire  [lrupr_pkg::CFG_W-1:0]         i_cfg_wdata
);

    lrupr_pkg::t_dp_cmd w_cmd;

    lrupr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    lrupr_dp #(
        .FRAMES_MAX (FRAMES_MAX),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page          (i_page),
        .i_end_of_run    (i_end_of_run),
        .o_fault         (o_fault),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for lru_page_replacement: predicts recency-stack outcomes and checks every result.
`timescale 1ns / 100ps

module tb;

    localparam int STACK_DEPTH = 16;
    localparam int PORT_PAGE_W = lrupr_pkg::PORT_PAGE_W;
    localparam int TOTAL_W     = lrupr_pkg::TOTAL_W;
    localparam int CFG_W       = lrupr_pkg::CFG_W;

    class lru_scoreboard;
        typedef struct packed {
            logic                   fault;
            logic                   evicted_valid;
            logic [PORT_PAGE_W-1:0] evicted_page;
            logic [TOTAL_W-1:0]     fault_total;
        } t_outcome;

        logic [PORT_PAGE_W-1:0] stack [STACK_DEPTH];
        int unsigned            resident;
        logic [TOTAL_W-1:0]     faults;
        logic [CFG_W-1:0]       frames_reg;
        t_outcome               pending_outcomes [$];
        int unsigned            errors, checked, hits, evictions, run_ends;

        function new();
            resident   = 0;
            faults     = '0;
            frames_reg = lrupr_pkg::FRAMES_RESET;
            errors     = 0;
            checked    = 0;
            hits       = 0;
            evictions  = 0;
            run_ends   = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] v);
            frames_reg = v;
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction

        // entries above pos slide down one slot, page lands on top
        function void push_front(int unsigned pos, logic [PORT_PAGE_W-1:0] pg);
            for (int unsigned k = pos; k > 0; k--)
                stack[k] = stack[k-1];
            stack[0] = pg;
        endfunction

        function void note_reference(logic [PORT_PAGE_W-1:0] pg, logic eor);
            t_outcome    o;
            int unsigned frames;
            int unsigned pos;
            bit          hit;
            o      = '0;
            frames = (frames_reg == 0) ? 1 :
                     (frames_reg > STACK_DEPTH) ? STACK_DEPTH : frames_reg;
            hit    = 0;
            pos    = resident;
            for (int unsigned k = 0; k < resident; k++) begin
                if (!hit && stack[k] == pg) begin
                    hit = 1;
                    pos = k;
                end
            end
            if (hit) begin
                push_front(pos, pg);
                hits++;
            end else begin
                o.fault = 1'b1;
                if (resident < frames) begin
                    push_front(resident, pg);
                    resident++;
                end else begin
                    // table full, or frame count lowered below occupancy
                    o.evicted_valid = 1'b1;
                    o.evicted_page  = stack[resident-1];
                    push_front(resident - 1, pg);
                    evictions++;
                end
                if (faults != '1)
                    faults++;
            end
            o.fault_total = faults;
            pending_outcomes.insert(pending_outcomes.size(), o);
            if (eor) begin
                resident = 0;
                faults   = '0;
                run_ends++;
            end
        endfunction

        function void check_outcome(logic f, logic ev, logic [PORT_PAGE_W-1:0] evp,
                                    logic [TOTAL_W-1:0] total);
            t_outcome exp_o;
            if (pending_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: fault=%0b evicted=%0b page=%h total=%0d",
                             $realtime, f, ev, evp, total);
                return;
            end
            exp_o = pending_outcomes.pop_front();
            checked++;
            if (f !== exp_o.fault || ev !== exp_o.evicted_valid ||
                evp !== exp_o.evicted_page || total !== exp_o.fault_total) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result %0d: expected fault=%0b evicted=%0b page=%h total=%0d,",
                             $realtime, checked, exp_o.fault, exp_o.evicted_valid,
                             exp_o.evicted_page, exp_o.fault_total,
                             " got fault=%0b evicted=%0b page=%h total=%0d",
                             f, ev, evp, total);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [PORT_PAGE_W-1:0] i_page;
    logic                   i_end_of_run;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_fault;
    logic                   o_evicted_valid;
    logic [PORT_PAGE_W-1:0] o_evicted_page;
    logic [TOTAL_W-1:0]     o_fault_total;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_wdata;

    lru_page_replacement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_page          (i_page),
        .i_end_of_run    (i_end_of_run),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fault         (o_fault),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    lru_scoreboard sb = new();

    int unsigned send_idle;
    int unsigned recv_idle;
    bit          stall_req;
    int unsigned settings_used;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("lru_page_replacement: mismatch");
        $finish;
    end

    // result side: check each transaction, then pick next ready
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_outcome(o_fault, o_evicted_valid, o_evicted_page, o_fault_total);
            if (stall_req) begin
                stall_req  = 0;
                stall_left = 120;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // valid stays high between back-to-back references; caller lowers it at phase end
    task automatic reference_page(logic [PORT_PAGE_W-1:0] pg, logic eor);
        if ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_valid      <= 1'b1;
        i_page       <= pg;
        i_end_of_run <= eor;
        do @(posedge i_clk); while (!o_ready);
        sb.note_reference(pg, eor);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_frames(v);
        settings_used++;
    endtask

    initial begin
        logic [PORT_PAGE_W-1:0] pool [24];
        logic [CFG_W-1:0]       phase_frames [12];
        int unsigned            psize;
        logic [PORT_PAGE_W-1:0] pg;

        phase_frames = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd17, 5'd12,
                         5'd7, 5'd16, 5'd3, 5'd9};
        settings_used = 1;
        send_idle     = 0;
        recv_idle     = 0;
        stall_req     = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_page       <= '0;
        i_end_of_run <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting of four frames: fill, hit, evict all-ones and all-zeros pages
        reference_page(16'h0000, 1'b0);
        reference_page(16'hFFFF, 1'b0);
        reference_page(16'h0000, 1'b0);
        reference_page(16'h0001, 1'b0);
        reference_page(16'h0002, 1'b0);
        reference_page(16'h0003, 1'b0);
        reference_page(16'h0001, 1'b0);
        reference_page(16'hFFFF, 1'b1);

        // zero frames behaves as one
        write_frames(5'd0);
        reference_page(16'h5555, 1'b0);
        reference_page(16'h5555, 1'b0);
        reference_page(16'hAAAA, 1'b1);

        // above the table depth clamps to sixteen, then shrink with pages resident
        write_frames(5'd31);
        for (int k = 0; k < 10; k++)
            reference_page(PORT_PAGE_W'(16'h0100 + k), 1'b0);
        write_frames(5'd2);
        reference_page(16'h0100, 1'b0);
        reference_page(16'h0200, 1'b0);
        reference_page(16'h0200, 1'b1);

        for (int ph = 0; ph < 12; ph++) begin
            write_frames(phase_frames[ph]);
            case (ph / 4)
                0: begin
                    send_idle = 18;
                    recv_idle = 56;
                end
                1: begin
                    send_idle = 56;
                    recv_idle = 18;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (ph == 8)
                stall_req = 1;
            foreach (pool[i])
                pool[i] = PORT_PAGE_W'($urandom_range(0, 16'hFFFF));
            psize = $urandom_range(1, 24);
            for (int n = 0; n < 140; n++) begin
                if ($urandom_range(0, 9) == 0)
                    pg = PORT_PAGE_W'($urandom_range(0, 16'hFFFF));
                else
                    pg = pool[$urandom_range(0, psize - 1)];
                if ($urandom_range(0, 29) == 0)
                    psize = $urandom_range(1, 24);
                reference_page(pg, $urandom_range(0, 49) == 0);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d references over %0d frame settings: %0d hits, %0d evictions",
                 sb.checked, settings_used, sb.hits, sb.evictions);
        $display("%0d run ends, %0d failures", sb.run_ends, sb.errors);
        if (sb.errors == 0)
            $display("lru_page_replacement: match");
        else
            $display("lru_page_replacement: mismatch");
        $finish;
    end

endmodule
